>>> rtl/assert_macros.svh
// Assertion helpers; clk and rst_n come from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DMCV_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

`define DMCV_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition");

`endif

>>> rtl/dmcv_pkg.sv
package dmcv_pkg;

  localparam int SET_COUNT       = 64;
  localparam int WORDS_PER_BLOCK = 8;
  localparam int VICTIM_ENTRIES  = 8;
  localparam int ADDR_BITS       = 32;

  localparam int WORD_SHIFT = 3;
  localparam int WORD_W     = $clog2(WORDS_PER_BLOCK);
  localparam int SET_W      = $clog2(SET_COUNT);
  localparam int BLK_SHIFT  = WORD_W + WORD_SHIFT;
  localparam int TAG_W      = ADDR_BITS - BLK_SHIFT - SET_W;
  localparam int BADDR_W    = ADDR_BITS - BLK_SHIFT;
  localparam int VSLOT_W    = $clog2(VICTIM_ENTRIES);
  localparam int VCNT_W     = $clog2(VICTIM_ENTRIES + 1);
  localparam int MCNT_W     = $clog2(WORDS_PER_BLOCK + 1);
  localparam int LDATA_D    = SET_COUNT * WORDS_PER_BLOCK;
  localparam int VDATA_D    = VICTIM_ENTRIES * WORDS_PER_BLOCK;

  localparam int DW          = 64;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 136;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_LOAD_DONE  = 3'd0,
    STS_STORE_DONE = 3'd1,
    STS_MISS       = 3'd2,
    STS_BUSY       = 3'd3,
    STS_MISALIGN   = 3'd4
  } status_t;

  typedef struct packed {
    logic                swap;
    logic                push;
    logic [VSLOT_W-1:0]  pos;
    logic [VSLOT_W-1:0]  slot;
    logic                evict;
    logic [BADDR_W-1:0]  baddr;
    logic                dirty;
  } vl_op_t;

  typedef struct packed {
    logic                vhit;
    logic [VSLOT_W-1:0]  vpos;
    logic [VSLOT_W-1:0]  vslot;
    logic                vdirty;
    logic [VSLOT_W-1:0]  push_slot;
    logic                full;
    logic                drop_dirty;
    logic [BADDR_W-1:0]  drop_baddr;
  } vl_stat_t;

  typedef struct packed {
    status_t        status;
    logic [DW-1:0]  load_data;
    logic           vhit;
    logic [31:0]    req_addr;
    logic           wb;
    logic [31:0]    wb_addr;
  } res_t;

endpackage

>>> rtl/direct_mapped_cache_with_victim_fifo.sv
// Hit or miss request: result passes the lookup and emit states; busy or misaligned: emit only.
// Victim swap and block install (after the last fill word) copy the block a word at a time
// through the line and victim data RAMs.
// One access in flight; the next item is taken while a result waits for out_tready.
// Reset clears line valid/dirty flags, victim FIFO count and the pending access.
`include "assert_macros.svh"

module direct_mapped_cache_with_victim_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // address[31:0], data_word[95:32], fill_index[98:96], zero pad
  input  logic [dmcv_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command[1:0]
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // load_data[63:0], victim_hit[64], request_address[96:65],
  // writeback_flag[97], writeback_address[129:98], zero pad
  output logic [dmcv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[2:0]
  output logic [2:0]                          out_tuser
);
  import dmcv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_FILL = 5'b00100,
    S_MOVE = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic               pend_v_r, pend_v_nxt;
  logic               pend_st_r, pend_st_nxt;
  logic [31:0]        pend_a_r, pend_a_nxt;
  logic [DW-1:0]      pend_d_r, pend_d_nxt;
  logic               swap_r, swap_nxt;
  logic [MCNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [TAG_W-1:0]   old_tag_r, old_tag_nxt;
  logic [VSLOT_W-1:0] vslot_r, vslot_nxt;
  logic [VSLOT_W-1:0] vpos_r, vpos_nxt;
  logic               vdirty_r, vdirty_nxt;
  logic               line_v_r, line_v_nxt;
  logic               line_d_r, line_d_nxt;
  logic               full_r, full_nxt;
  logic               drop_d_r, drop_d_nxt;
  logic [BADDR_W-1:0] drop_ba_r, drop_ba_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r;
  logic               out_v_r;
  logic [DW-1:0]      fbuf_r [WORDS_PER_BLOCK];
  logic               lvalid_r [SET_COUNT];
  logic               ldirty_r [SET_COUNT];

  cmd_t               in_cmd;
  logic [31:0]        in_addr;
  logic [DW-1:0]      in_dw;
  logic [WORD_W-1:0]  in_fidx;
  logic               in_fire;
  logic               emit_go;

  logic [SET_W-1:0]   set_p;
  logic [TAG_W-1:0]   tag_p;
  logic [WORD_W-1:0]  wsel_p;
  logic [BADDR_W-1:0] baddr_p;
  logic [WORD_W-1:0]  widx;
  logic               mv_wr;
  logic               mv_done;
  logic [DW-1:0]      src_word;
  logic [DW-1:0]      new_word;

  logic               tag_we;
  logic [SET_W-1:0]   tag_ra;
  logic [TAG_W-1:0]   tag_rd;
  logic               ld_we;
  logic [SET_W+WORD_W-1:0] ld_wa, ld_ra;
  logic [DW-1:0]      ld_wd, ld_rd;
  logic               vd_we;
  logic [VSLOT_W+WORD_W-1:0] vd_wa, vd_ra;
  logic [DW-1:0]      vd_rd;

  vl_op_t             vop;
  vl_stat_t           vst;
  logic [VCNT_W-1:0]  vcount;
  logic               set_line;
  logic               set_dirty_val;

  assign in_cmd  = cmd_t'(in_tuser);
  assign in_addr = in_tdata[31:0];
  assign in_dw   = in_tdata[95:32];
  assign in_fidx = in_tdata[96 +: WORD_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_go   = (state_r == S_EMIT) && (!out_v_r || out_tready);

  assign set_p   = pend_a_r[BLK_SHIFT +: SET_W];
  assign tag_p   = pend_a_r[BLK_SHIFT+SET_W +: TAG_W];
  assign wsel_p  = pend_a_r[WORD_SHIFT +: WORD_W];
  assign baddr_p = pend_a_r[BLK_SHIFT +: BADDR_W];

  assign widx     = WORD_W'(mcnt_r - MCNT_W'(1));
  assign mv_wr    = (state_r == S_MOVE) && (mcnt_r != '0);
  assign mv_done  = (state_r == S_MOVE) && (mcnt_r == MCNT_W'(WORDS_PER_BLOCK));
  assign src_word = swap_r ? vd_rd : fbuf_r[widx];
  assign new_word = (pend_st_r && widx == wsel_p) ? pend_d_r : src_word;

  always_comb begin
    if (state_r == S_IDLE && in_cmd == CMD_FILL) begin
      tag_ra = set_p;
    end else begin
      tag_ra = in_addr[BLK_SHIFT +: SET_W];
    end
    if (state_r == S_MOVE) begin
      ld_ra = {set_p, mcnt_r[WORD_W-1:0]};
    end else begin
      ld_ra = {in_addr[BLK_SHIFT +: SET_W], in_addr[WORD_SHIFT +: WORD_W]};
    end
    vd_ra  = {vslot_r, mcnt_r[WORD_W-1:0]};
    tag_we = mv_done;
    vd_we  = mv_wr && line_v_r;
    vd_wa  = {vslot_r, widx};
    ld_we  = mv_wr;
    ld_wa  = {set_p, widx};
    ld_wd  = new_word;
    if (state_r == S_LOOK) begin
      ld_we = lvalid_r[set_p] && tag_rd == tag_p && pend_st_r;
      ld_wa = {set_p, wsel_p};
      ld_wd = pend_d_r;
    end
  end

  dmcv_ram #(.WIDTH(TAG_W), .DEPTH(SET_COUNT)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(set_p), .wdata(tag_p),
    .raddr(tag_ra), .rdata(tag_rd)
  );

  dmcv_ram #(.WIDTH(DW), .DEPTH(LDATA_D)) u_line_ram (
    .clk(clk), .we(ld_we), .waddr(ld_wa), .wdata(ld_wd),
    .raddr(ld_ra), .rdata(ld_rd)
  );

  dmcv_ram #(.WIDTH(DW), .DEPTH(VDATA_D)) u_victim_ram (
    .clk(clk), .we(vd_we), .waddr(vd_wa), .wdata(ld_rd),
    .raddr(vd_ra), .rdata(vd_rd)
  );

  always_comb begin
    vop       = '0;
    vop.pos   = vpos_r;
    vop.slot  = vslot_r;
    vop.evict = line_v_r;
    vop.baddr = {old_tag_r, set_p};
    vop.dirty = line_d_r;
    if (mv_done) begin
      vop.swap = swap_r;
      vop.push = !swap_r && line_v_r;
    end
  end

  dmcv_vlist u_vlist (
    .clk(clk), .rst_n(rst_n), .find_baddr(baddr_p), .op(vop),
    .st(vst), .count(vcount)
  );

  always_comb begin
    state_nxt   = state_r;
    pend_v_nxt  = pend_v_r;
    pend_st_nxt = pend_st_r;
    pend_a_nxt  = pend_a_r;
    pend_d_nxt  = pend_d_r;
    swap_nxt    = swap_r;
    mcnt_nxt    = mcnt_r;
    old_tag_nxt = old_tag_r;
    vslot_nxt   = vslot_r;
    vpos_nxt    = vpos_r;
    vdirty_nxt  = vdirty_r;
    line_v_nxt  = line_v_r;
    line_d_nxt  = line_d_r;
    full_nxt    = full_r;
    drop_d_nxt  = drop_d_r;
    drop_ba_nxt = drop_ba_r;
    res_nxt     = res_r;
    set_line    = 1'b0;
    set_dirty_val = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_FILL: begin
              if (pend_v_r && in_tlast) begin
                state_nxt = S_FILL;
              end
            end
            CMD_LOAD, CMD_STORE: begin
              res_nxt = '0;
              if (pend_v_r) begin
                res_nxt.status = STS_BUSY;
                state_nxt = S_EMIT;
              end else if (in_addr[WORD_SHIFT-1:0] != '0) begin
                res_nxt.status = STS_MISALIGN;
                state_nxt = S_EMIT;
              end else begin
                pend_a_nxt  = in_addr;
                pend_st_nxt = (in_cmd == CMD_STORE);
                pend_d_nxt  = in_dw;
                state_nxt   = S_LOOK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOK: begin
        if (lvalid_r[set_p] && tag_rd == tag_p) begin
          if (pend_st_r) begin
            res_nxt.status = STS_STORE_DONE;
            set_line = 1'b1;
            set_dirty_val = 1'b1;
          end else begin
            res_nxt.status    = STS_LOAD_DONE;
            res_nxt.load_data = ld_rd;
          end
          state_nxt = S_EMIT;
        end else if (vst.vhit) begin
          vpos_nxt    = vst.vpos;
          vslot_nxt   = vst.vslot;
          vdirty_nxt  = vst.vdirty;
          old_tag_nxt = tag_rd;
          line_v_nxt  = lvalid_r[set_p];
          line_d_nxt  = ldirty_r[set_p];
          swap_nxt    = 1'b1;
          mcnt_nxt    = '0;
          state_nxt   = S_MOVE;
        end else begin
          pend_v_nxt       = 1'b1;
          res_nxt.status   = STS_MISS;
          res_nxt.req_addr = {baddr_p, {BLK_SHIFT{1'b0}}};
          state_nxt        = S_EMIT;
        end
      end
      S_FILL: begin
        old_tag_nxt = tag_rd;
        line_v_nxt  = lvalid_r[set_p];
        line_d_nxt  = ldirty_r[set_p];
        vslot_nxt   = vst.push_slot;
        full_nxt    = vst.full;
        drop_d_nxt  = vst.drop_dirty;
        drop_ba_nxt = vst.drop_baddr;
        swap_nxt    = 1'b0;
        mcnt_nxt    = '0;
        res_nxt     = '0;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        if (mv_wr && !pend_st_r && widx == wsel_p) begin
          res_nxt.load_data = src_word;
        end
        if (mv_done) begin
          res_nxt.status = pend_st_r ? STS_STORE_DONE : STS_LOAD_DONE;
          res_nxt.vhit   = swap_r;
          res_nxt.wb     = !swap_r && line_v_r && full_r && drop_d_r;
          res_nxt.wb_addr = res_nxt.wb ? {drop_ba_r, {BLK_SHIFT{1'b0}}} : '0;
          set_line      = 1'b1;
          set_dirty_val = swap_r ? (vdirty_r || pend_st_r) : pend_st_r;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_EMIT;
        end else begin
          mcnt_nxt = mcnt_r + MCNT_W'(1);
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_st_r <= pend_st_nxt;
    pend_a_r  <= pend_a_nxt;
    pend_d_r  <= pend_d_nxt;
    swap_r    <= swap_nxt;
    mcnt_r    <= mcnt_nxt;
    old_tag_r <= old_tag_nxt;
    vslot_r   <= vslot_nxt;
    vpos_r    <= vpos_nxt;
    vdirty_r  <= vdirty_nxt;
    line_v_r  <= line_v_nxt;
    line_d_r  <= line_d_nxt;
    full_r    <= full_nxt;
    drop_d_r  <= drop_d_nxt;
    drop_ba_r <= drop_ba_nxt;
    res_r     <= res_nxt;
    if (emit_go) begin
      out_r <= res_r;
    end
    if (in_fire && in_cmd == CMD_FILL && pend_v_r) begin
      fbuf_r[in_fidx] <= in_dw;
    end
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < SET_COUNT; i++) begin
        lvalid_r[i] <= 1'b0;
        ldirty_r[i] <= 1'b0;
      end
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (set_line) begin
        lvalid_r[set_p] <= 1'b1;
        ldirty_r[set_p] <= set_dirty_val;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'b0, out_r.wb_addr, out_r.wb, out_r.req_addr,
                       out_r.vhit, out_r.load_data};

  `DMCV_CHECK(a_look_not_pending, (state_r == S_LOOK) |-> !pend_v_r)
  `DMCV_NEVER(a_victim_count, vcount > VCNT_W'(VICTIM_ENTRIES))
  `DMCV_CHECK(a_move_count, (state_r == S_MOVE) |-> (mcnt_r <= MCNT_W'(WORDS_PER_BLOCK)))

endmodule

>>> rtl/dmcv_ram.sv
module dmcv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dmcv_vlist.sv
module dmcv_vlist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dmcv_pkg::BADDR_W-1:0]  find_baddr,
  input  dmcv_pkg::vl_op_t              op,
  output dmcv_pkg::vl_stat_t            st,
  output logic [dmcv_pkg::VCNT_W-1:0]   count
);
  import dmcv_pkg::*;

  logic [BADDR_W-1:0] ba_r  [VICTIM_ENTRIES];
  logic [BADDR_W-1:0] ba_nxt[VICTIM_ENTRIES];
  logic               dt_r  [VICTIM_ENTRIES];
  logic               dt_nxt[VICTIM_ENTRIES];
  logic [VSLOT_W-1:0] sl_r  [VICTIM_ENTRIES];
  logic [VSLOT_W-1:0] sl_nxt[VICTIM_ENTRIES];
  logic [VCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VCNT_W-1:0]  last_p;

  assign count = cnt_r;
  assign last_p = cnt_r - VCNT_W'(1);

  always_comb begin
    st = '0;
    for (int p = VICTIM_ENTRIES - 1; p >= 0; p--) begin
      if (VCNT_W'(p) < cnt_r && ba_r[p] == find_baddr) begin
        st.vhit = 1'b1;
        st.vpos = VSLOT_W'(p);
      end
    end
    st.vslot      = sl_r[st.vpos];
    st.vdirty     = dt_r[st.vpos];
    st.full       = (cnt_r == VCNT_W'(VICTIM_ENTRIES));
    st.push_slot  = st.full ? sl_r[0] : sl_r[cnt_r[VSLOT_W-1:0]];
    st.drop_dirty = dt_r[0];
    st.drop_baddr = ba_r[0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int p = 0; p < VICTIM_ENTRIES; p++) begin
      ba_nxt[p] = ba_r[p];
      dt_nxt[p] = dt_r[p];
      sl_nxt[p] = sl_r[p];
    end
    if (op.swap) begin
      for (int p = 0; p < VICTIM_ENTRIES - 1; p++) begin
        if (VCNT_W'(p) >= VCNT_W'(op.pos) && VCNT_W'(p) < last_p) begin
          ba_nxt[p] = ba_r[p+1];
          dt_nxt[p] = dt_r[p+1];
          sl_nxt[p] = sl_r[p+1];
        end
      end
      for (int p = 0; p < VICTIM_ENTRIES; p++) begin
        if (VCNT_W'(p) == last_p) begin
          ba_nxt[p] = op.baddr;
          dt_nxt[p] = op.dirty;
          sl_nxt[p] = op.slot;
        end
      end
      if (!op.evict) begin
        cnt_nxt = last_p;
      end
    end else if (op.push) begin
      if (cnt_r == VCNT_W'(VICTIM_ENTRIES)) begin
        for (int p = 0; p < VICTIM_ENTRIES - 1; p++) begin
          ba_nxt[p] = ba_r[p+1];
          dt_nxt[p] = dt_r[p+1];
          sl_nxt[p] = sl_r[p+1];
        end
        ba_nxt[VICTIM_ENTRIES-1] = op.baddr;
        dt_nxt[VICTIM_ENTRIES-1] = op.dirty;
        sl_nxt[VICTIM_ENTRIES-1] = op.slot;
      end else begin
        for (int p = 0; p < VICTIM_ENTRIES; p++) begin
          if (VCNT_W'(p) == cnt_r) begin
            ba_nxt[p] = op.baddr;
            dt_nxt[p] = op.dirty;
            sl_nxt[p] = op.slot;
          end
        end
        cnt_nxt = cnt_r + VCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < VICTIM_ENTRIES; p++) begin
      ba_r[p] <= ba_nxt[p];
    end
    if (!rst_n) begin
      cnt_r <= '0;
      for (int p = 0; p < VICTIM_ENTRIES; p++) begin
        dt_r[p] <= 1'b0;
        sl_r[p] <= VSLOT_W'(p);
      end
    end else begin
      cnt_r <= cnt_nxt;
      for (int p = 0; p < VICTIM_ENTRIES; p++) begin
        dt_r[p] <= dt_nxt[p];
        sl_r[p] <= sl_nxt[p];
      end
    end
  end

endmodule
